### rtl/core/servo_pulse_sweeper_assert.svh
// ----------------------------------------------------------------------------
// servo pulse sweeper assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_SWEEPER_ASSERT_SVH
`define SERVO_PULSE_SWEEPER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// shared widths, codes, constants and helpers for the servo pulse sweeper
// ----------------------------------------------------------------------------
package sps_pkg;

  // pwm timing
  localparam int PWM_RESOLUTION  = 4096;
  localparam int SERVO_PERIOD_US = 20000;

  // field widths
  localparam int OP_W       = 2;
  localparam int MS_W       = 32;
  localparam int CH_W       = 4;
  localparam int PULSE_W    = 16;
  localparam int SPULSE_W   = PULSE_W + 2;
  localparam int TICK_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_ENABLE = 2'd2;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd3;

  // reset values
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2000;
  localparam logic [PULSE_W-1:0] STEP_RST      = 16'd10;
  localparam logic [MS_W-1:0]    INTERVAL_RST  = 32'd20;
  localparam logic [PULSE_W-1:0] PULSE_RST     = 16'd1500;

  // tick conversion: n = pulse * resolution + period / 2, ticks = n / period
  localparam int NUM_W   = PULSE_W + $clog2(PWM_RESOLUTION) + 1;
  localparam int SHIFT_L = $clog2(SERVO_PERIOD_US + 1) - 1;
  localparam int NSH_W   = NUM_W - SHIFT_L;
  localparam int Q_W     = NUM_W - SHIFT_L;
  localparam longint unsigned RECIP = (64'd1 << NUM_W) / SERVO_PERIOD_US;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int MUL1_W  = NSH_W + RECIP_W;
  localparam int MUL2_W  = Q_W + PULSE_W;
  localparam int CAP_W   = (Q_W > TICK_W) ? Q_W : TICK_W;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [PULSE_W-1:0] pulse;
  } sps_res_t;

  // clamp, min tested first so inverted limits pin low values to min
  function automatic logic signed [SPULSE_W-1:0] limit_pulse(
    input logic signed [SPULSE_W-1:0] p,
    input logic [PULSE_W-1:0]         lo,
    input logic [PULSE_W-1:0]         hi
  );
    logic signed [SPULSE_W-1:0] lo_s;
    logic signed [SPULSE_W-1:0] hi_s;
    lo_s = signed'({2'b00, lo});
    hi_s = signed'({2'b00, hi});
    if (p < lo_s) begin
      return lo_s;
    end else if (p > hi_s) begin
      return hi_s;
    end
    return p;
  endfunction

endpackage

### rtl/core/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl
// input register, config registers and sweep state update
// ----------------------------------------------------------------------------
`include "servo_pulse_sweeper_assert.svh"

module sps_ctrl import sps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [MS_W-1:0]       in_now_ms,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [PULSE_W-1:0]    in_pulse_us,
  input  logic                  in_sweep_on,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sps_res_t              res
);

  logic [PULSE_W-1:0] min_r, max_r, step_r;
  logic [MS_W-1:0]    ivl_r;

  logic               v0_r;
  logic [OP_W-1:0]    op_r;
  logic [MS_W-1:0]    now_r;
  logic [CH_W-1:0]    ch_r;
  logic [PULSE_W-1:0] req_r;
  logic               on_r;

  logic [PULSE_W-1:0] cur_r, cur_nxt;
  logic               down_r, down_nxt;
  logic [MS_W-1:0]    last_r, last_nxt;
  logic               sweep_r, sweep_nxt;
  logic [CH_W-1:0]    chan_r, chan_nxt;

  logic               v1_r;
  sps_res_t           res_r;

  logic                       rdy1, rdy0, fire0, emit;
  logic [MS_W-1:0]            elapsed;
  logic                       due;
  logic signed [SPULSE_W-1:0] sum, stepped, out_p;
  logic                       hit;
  logic [CH_W-1:0]            emit_ch;

  assign rdy1     = !v1_r || res_ready;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;
  assign fire0    = v0_r && rdy1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_PULSE_RST;
      max_r  <= MAX_PULSE_RST;
      step_r <= STEP_RST;
      ivl_r  <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PULSE: min_r  <= cfg_wdata[PULSE_W-1:0];
        CFG_MAX_PULSE: max_r  <= cfg_wdata[PULSE_W-1:0];
        CFG_STEP:      step_r <= cfg_wdata[PULSE_W-1:0];
        CFG_INTERVAL:  ivl_r  <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      op_r  <= in_opcode;
      now_r <= in_now_ms;
      ch_r  <= in_channel;
      req_r <= in_pulse_us;
      on_r  <= in_sweep_on;
    end
  end

  // sweep step arithmetic
  assign elapsed = now_r - last_r;
  assign due     = sweep_r && (elapsed >= ivl_r);
  assign sum     = down_r ? signed'({2'b00, cur_r}) - signed'({2'b00, step_r})
                          : signed'({2'b00, cur_r}) + signed'({2'b00, step_r});
  assign hit     = (sum >= signed'({2'b00, max_r})) || (sum <= signed'({2'b00, min_r}));
  assign stepped = hit ? limit_pulse(sum, min_r, max_r) : sum;

  always_comb begin
    cur_nxt   = cur_r;
    down_nxt  = down_r;
    last_nxt  = last_r;
    sweep_nxt = sweep_r;
    chan_nxt  = chan_r;
    emit      = 1'b0;
    emit_ch   = chan_r;
    unique case (op_r)
      OP_TICK: begin
        if (due) begin
          emit     = 1'b1;
          last_nxt = now_r;
          cur_nxt  = stepped[PULSE_W-1:0];
          down_nxt = hit ? !down_r : down_r;
        end
      end
      OP_SET: begin
        emit      = 1'b1;
        emit_ch   = ch_r;
        chan_nxt  = ch_r;
        sweep_nxt = 1'b0;
        cur_nxt   = PULSE_W'(limit_pulse(signed'({2'b00, req_r}), min_r, max_r));
      end
      OP_ENABLE: begin
        sweep_nxt = on_r;
        if (on_r) begin
          last_nxt = '0;
        end
      end
      OP_SELECT: begin
        chan_nxt = ch_r;
      end
      default: ;
    endcase
  end

  // the written value is clamped once more against the current limits
  assign out_p = limit_pulse(signed'({2'b00, cur_nxt}), min_r, max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= PULSE_RST;
      down_r  <= 1'b0;
      last_r  <= '0;
      sweep_r <= 1'b0;
      chan_r  <= '0;
    end else if (fire0) begin
      cur_r   <= cur_nxt;
      down_r  <= down_nxt;
      last_r  <= last_nxt;
      sweep_r <= sweep_nxt;
      chan_r  <= chan_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire0 && emit) begin
      res_r.channel <= emit_ch;
      res_r.pulse   <= out_p[PULSE_W-1:0];
    end
  end

  assign res_valid = v1_r;
  assign res       = res_r;

  `SPS_ASSERT_NEXT(a_pulse_holds, !fire0, $stable(cur_r), "pulse changed without an item")
  `SPS_ASSERT_NEXT(a_set_stops_sweep, fire0 && (op_r == OP_SET), !sweep_r,
                   "set target left sweep running")

endmodule

### rtl/core/sps_ticks.sv
// ----------------------------------------------------------------------------
// sps_ticks
// pulse to pwm off-count: reciprocal multiply, remainder fix-up and cap
// ----------------------------------------------------------------------------
`include "servo_pulse_sweeper_assert.svh"

module sps_ticks import sps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  sps_res_t           res,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CH_W-1:0]    out_channel,
  output logic [PULSE_W-1:0] out_pulse_us,
  output logic [TICK_W-1:0]  out_pwm_ticks
);

  localparam logic [NUM_W-1:0] NUM_RES  = NUM_W'(PWM_RESOLUTION);
  localparam logic [NUM_W-1:0] NUM_HALF = NUM_W'(SERVO_PERIOD_US / 2);
  localparam logic [NUM_W-1:0] DIV_1X   = NUM_W'(SERVO_PERIOD_US);
  localparam logic [NUM_W-1:0] DIV_2X   = NUM_W'(2 * SERVO_PERIOD_US);
  localparam logic [NUM_W-1:0] DIV_3X   = NUM_W'(3 * SERVO_PERIOD_US);
  localparam logic [Q_W-1:0]   TICK_CAP = Q_W'(PWM_RESOLUTION - 1);

  logic v2_r, v3_r, v4_r, v5_r;
  logic rdy2, rdy3, rdy4, rdy5;

  sps_res_t         s2_r, s3_r, s4_r, s5_r;
  logic [NUM_W-1:0] n2_r, n3_r, n4_r;
  logic [Q_W-1:0]   qe3_r, qe4_r;
  logic [NUM_W-1:0] pr4_r;
  logic [TICK_W-1:0] tick5_r;

  logic [NSH_W-1:0]  nsh;
  logic [MUL1_W-1:0] mul1;
  logic [MUL2_W-1:0] mul2;
  logic [NUM_W-1:0]  rem;
  logic [Q_W-1:0]    q_fix, q_cap;
  logic [CAP_W-1:0]  q_ext;

  assign rdy5      = !v5_r || out_ready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign res_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= res_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // numerator: pulse scaled plus half a period for rounding
  always_ff @(posedge clk) begin
    if (rdy2 && res_valid) begin
      s2_r <= res;
      n2_r <= NUM_W'(res.pulse) * NUM_RES + NUM_HALF;
    end
  end

  // quotient estimate, at most two below the true value
  assign nsh  = n2_r[NUM_W-1:SHIFT_L];
  assign mul1 = MUL1_W'(nsh) * MUL1_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_r  <= s2_r;
      n3_r  <= n2_r;
      qe3_r <= Q_W'(mul1 >> (NUM_W - SHIFT_L));
    end
  end

  assign mul2 = MUL2_W'(qe3_r) * MUL2_W'(SERVO_PERIOD_US);

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      s4_r  <= s3_r;
      n4_r  <= n3_r;
      qe4_r <= qe3_r;
      pr4_r <= NUM_W'(mul2);
    end
  end

  // remainder fix-up and cap
  assign rem   = n4_r - pr4_r;
  assign q_fix = qe4_r + Q_W'(rem >= DIV_1X) + Q_W'(rem >= DIV_2X);
  assign q_cap = (q_fix > TICK_CAP) ? TICK_CAP : q_fix;
  assign q_ext = CAP_W'(q_cap);

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      s5_r    <= s4_r;
      tick5_r <= q_ext[TICK_W-1:0];
    end
  end

  assign out_valid     = v5_r;
  assign out_channel   = s5_r.channel;
  assign out_pulse_us  = s5_r.pulse;
  assign out_pwm_ticks = tick5_r;

  `SPS_ASSERT_NOW(a_est_below, v4_r, pr4_r <= n4_r, "quotient estimate too high")
  `SPS_ASSERT_NOW(a_rem_range, v4_r, rem < DIV_3X, "remainder beyond fix-up range")

endmodule

### rtl/core/servo_pulse_sweeper.sv
// ----------------------------------------------------------------------------
// servo_pulse_sweeper
// path: input register, result register, then the tick stages to out_valid
// throughput: one item per cycle unless out_ready back-pressure stalls the pipeline
// reset: synchronous on rst_n low; limits, step, interval, pulse 1500 restored
// ----------------------------------------------------------------------------
//
// Items land in an input register. The control stage updates the sweep state
// (pulse, direction, last step time, sweep flag, channel) and places any pulse
// write in a result register. Items that write nothing
// (sweep enable, channel select, a tick before the interval) retire there.
// The write then runs through the tick pipeline:
//   - numerator = pulse * resolution + half period
//   - reciprocal multiply on the numerator with its low bits dropped
//   - estimate times period, remainder formed
//   - up to two remainder fix-ups, cap at resolution minus one
// Every stage has its own valid bit and stalls only when the stage ahead is
// full and blocked, so a bubble is always filled and the block keeps
// taking transfers while a finished result waits on out_ready, until full.

module servo_pulse_sweeper import sps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [MS_W-1:0]       in_now_ms,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [PULSE_W-1:0]    in_pulse_us,
  input  logic                  in_sweep_on,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_channel,
  output logic [PULSE_W-1:0]    out_pulse_us,
  output logic [TICK_W-1:0]     out_pwm_ticks
);

  // pulse write handed from the control stage to the tick pipeline
  logic     res_valid;
  logic     res_ready;
  sps_res_t res;

  sps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_now_ms   (in_now_ms),
    .in_channel  (in_channel),
    .in_pulse_us (in_pulse_us),
    .in_sweep_on (in_sweep_on),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // pwm off-count conversion, pulse and channel ride along
  sps_ticks u_ticks (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_pulse_us  (out_pulse_us),
    .out_pwm_ticks (out_pwm_ticks)
  );

endmodule
